[rtl/rtt_pkg.sv]
package rtt_pkg;

	localparam int unsigned EST_RESET  = 1000000;
	localparam int unsigned GAIN_RESET = 6554;
	localparam int unsigned MAXM_RESET = 64;

	typedef enum logic [1:0] {
		CFG_GAIN     = 2'd0,
		CFG_INIT_EST = 2'd1,
		CFG_MAX_MULT = 2'd2
	} rtt_cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_SENT    = 3'd0,
		MODE_ACK     = 3'd1,
		MODE_BACKOFF = 3'd2,
		MODE_CLEAR   = 3'd3,
		MODE_RESET   = 3'd4
	} rtt_mode_t;

	typedef struct packed {
		logic        retx;
		logic [31:0] stamp;
		logic [31:0] len;
		logic [31:0] start;
	} rtt_ent_t;

	typedef struct packed {
		logic go;
		logic smp;
		logic clr;
	} rtt_flt_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_ACK_RD,
		ST_ACK_CMP,
		ST_FILT_GO,
		ST_FILT_WAIT,
		ST_OUT
	} rtt_state_t;

	typedef enum logic [2:0] {
		FL_IDLE,
		FL_MUL1,
		FL_ADD1,
		FL_MUL2,
		FL_ADD2,
		FL_TBASE,
		FL_TMUL,
		FL_DONE
	} rtt_flt_state_t;

endpackage

[rtl/rtt_if.sv]
interface rtt_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] seq;
	logic [15:0] length;
	logic [31:0] now_time;

	modport source (output valid, mode, seq, length, now_time, input ready);
	modport sink (input valid, mode, seq, length, now_time, output ready);
endinterface

interface rtt_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] rtt_sample;
	logic        sample_valid;
	logic [47:0] timeout_value;
	logic [31:0] smoothed_rtt;
	logic [31:0] mean_deviation;
	logic [10:0] backoff_level;
	logic        history_full_drop;
	logic [5:0]  pending_ranges;

	modport source (output valid, rtt_sample, sample_valid, timeout_value, smoothed_rtt,
		mean_deviation, backoff_level, history_full_drop, pending_ranges, input ready);
	modport sink (input valid, rtt_sample, sample_valid, timeout_value, smoothed_rtt,
		mean_deviation, backoff_level, history_full_drop, pending_ranges, output ready);
endinterface

[rtl/rtt_hist_mem.sv]
module rtt_hist_mem
	import rtt_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rtt_ent_t      wdata,
	input  logic [AW-1:0] raddr,
	output rtt_ent_t      rdata
);

	rtt_ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rtt_filter.sv]
module rtt_filter
	import rtt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rtt_flt_cmd_t cmd,
	input  logic [31:0]  sample,
	input  logic [31:0]  init_est,
	input  logic [15:0]  gain,
	input  logic [10:0]  backoff,
	output logic [31:0]  est,
	output logic [31:0]  dev,
	output logic [47:0]  tmo,
	output logic         done
);

	rtt_flt_state_t state_q, state_d;
	logic [31:0]        est_q, dev_q;
	logic               have_q;
	logic signed [32:0] err_q;
	logic [32:0]        mag_q;
	logic signed [33:0] dd_q;
	logic signed [50:0] prod_q;
	logic [34:0]        base_q;
	logic [47:0]        tmo_q;
	logic signed [32:0] err_c;
	logic [33:0]        dev4_c;
	logic [45:0]        tprod_c;

	assign err_c   = $signed({1'b0, sample}) - $signed({1'b0, est_q});
	assign dev4_c  = {dev_q, 2'b00};
	assign tprod_c = base_q * backoff;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FL_IDLE:  if (cmd.go) state_d = (cmd.smp && have_q) ? FL_MUL1 : FL_TBASE;
			FL_MUL1:  state_d = FL_ADD1;
			FL_ADD1:  state_d = FL_MUL2;
			FL_MUL2:  state_d = FL_ADD2;
			FL_ADD2:  state_d = FL_TBASE;
			FL_TBASE: state_d = FL_TMUL;
			FL_TMUL:  state_d = FL_DONE;
			FL_DONE:  state_d = FL_IDLE;
			default:  state_d = FL_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == FL_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FL_IDLE;
			est_q   <= EST_RESET[31:0];
			dev_q   <= '0;
			have_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clr) begin
				est_q  <= init_est;
				dev_q  <= '0;
				have_q <= 1'b0;
			end else begin
				case (state_q)
					FL_IDLE: begin
						if (cmd.go && cmd.smp && !have_q) begin
							est_q  <= sample;
							dev_q  <= sample;
							have_q <= 1'b1;
						end
					end
					FL_ADD1: est_q <= est_q + prod_q[47:16];
					FL_ADD2: dev_q <= dev_q + prod_q[47:16];
					default: ;
				endcase
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			FL_IDLE: begin
				err_q <= err_c;
				mag_q <= err_c[32] ? 33'(-err_c) : 33'(err_c);
			end
			FL_MUL1: prod_q <= 51'(err_q * $signed({1'b0, gain}));
			FL_ADD1: dd_q   <= $signed({1'b0, mag_q}) - $signed({2'b00, dev_q});
			FL_MUL2: prod_q <= 51'(dd_q * $signed({1'b0, gain}));
			FL_TBASE: begin
				if (dev4_c < {2'b00, est_q}) base_q <= {2'b00, est_q, 1'b0};
				else base_q <= {3'b000, est_q} + {1'b0, dev4_c};
			end
			FL_TMUL: tmo_q <= {2'b00, tprod_c};
			default: ;
		endcase
	end

	assign est = est_q;
	assign dev = dev_q;
	assign tmo = tmo_q;

endmodule

[rtl/tcp_rtt_estimator_with_backoff.sv]
// Path: an accepted beat runs FILT_GO, FILT_WAIT and OUT, where the result loads; sends
//   without search, timeout, clear and reset beats take only this path. A later sample
//   adds filter steps MUL1 to ADD2; a retransmission first scans history, an ack first
//   reads it (every popped range, plus the range that stops the walk if one is left).
// Flow: one beat at a time; the next beat is accepted the cycle after the result
//   register loads. History ring is a single-port-read memory walked one entry at a
//   time, a read step then a compare step; both filter gain products share one register.
// Reset: arst_n asynchronous, active low; control and filter state cleared, no memory sweep.
module tcp_rtt_estimator_with_backoff
	import rtt_pkg::*;
#(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	rtt_item_if.sink    item,
	rtt_res_if.source   result
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int UW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
	localparam logic [UW-1:0] DEPTH_U = UW'(HISTORY_DEPTH);

	// configuration registers
	logic [15:0] gain_q;
	logic [31:0] init_q;
	logic [10:0] maxm_q;

	rtt_state_t state_q, state_d;

	// history ring control
	logic [31:0]   nexp_q;
	logic [AW-1:0] head_q;
	logic [UW-1:0] used_q;
	logic [AW-1:0] i_q;
	logic          first_q;
	logic [10:0]   backoff_q;

	// held beat
	logic [31:0] seq_q, now_q;
	logic [31:0] len_q;
	logic [31:0] sample_q;
	logic        smp_q, drop_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	rtt_ent_t      mem_wdata, rd;

	rtt_flt_cmd_t flt_cmd;
	logic [31:0]  est, dev;
	logic [47:0]  tmo;
	logic         flt_done;

	logic [AW-1:0] off_c, slot_c;
	logic [AW:0]   sum_c;
	logic [31:0]   rend_c, item_end_c;
	logic [31:0]   rend_new_c;
	logic          match_c, pop_c, take_c, accept;
	logic [10:0]   lim_c;
	logic [11:0]   dbl_c;
	logic [UW+5:0] pend_x;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	// ring slot of offset: head plus offset, wrapped once
	assign off_c  = (state_q == ST_IDLE) ? used_q[AW-1:0] : i_q;
	assign sum_c  = {1'b0, head_q} + {1'b0, off_c};
	assign slot_c = (sum_c >= DEPTH_W) ? AW'(sum_c - DEPTH_W) : sum_c[AW-1:0];

	assign item_end_c = item.seq + 32'(item.length);
	assign rend_c     = rd.start + rd.len;
	assign match_c    = (seq_q >= rd.start) && (seq_q < rend_c);
	assign pop_c      = (rend_c <= seq_q);
	assign take_c     = first_q && !rd.retx && (seq_q >= rend_c);

	assign lim_c = (maxm_q == '0) ? 11'd1 : maxm_q;
	assign dbl_c = {backoff_q, 1'b0};

	// end of the resent range, from the held beat
	assign rend_new_c = seq_q + len_q;

	rtt_hist_mem #(
		.DEPTH(HISTORY_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	rtt_filter u_flt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (flt_cmd),
		.sample  (sample_q),
		.init_est(init_q),
		.gain    (gain_q),
		.backoff (backoff_q),
		.est     (est),
		.dev     (dev),
		.tmo     (tmo),
		.done    (flt_done)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_SENT: begin
							if (item.seq != nexp_q && used_q != '0) state_d = ST_SRCH_RD;
							else state_d = ST_FILT_GO;
						end
						MODE_ACK: state_d = (used_q != '0) ? ST_ACK_RD : ST_FILT_GO;
						default:  state_d = ST_FILT_GO;
					endcase
				end
			end
			ST_SRCH_RD: state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				if (match_c || (UW'(i_q) + UW'(1) == used_q)) state_d = ST_FILT_GO;
				else state_d = ST_SRCH_RD;
			end
			ST_ACK_RD: state_d = ST_ACK_CMP;
			ST_ACK_CMP: state_d = (pop_c && used_q > UW'(1)) ? ST_ACK_RD : ST_FILT_GO;
			ST_FILT_GO: state_d = ST_FILT_WAIT;
			ST_FILT_WAIT: if (flt_done) state_d = ST_OUT;
			ST_OUT: if (!result.valid || result.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_c;
		mem_wdata = '0;
		mem_raddr = (state_q == ST_ACK_RD) ? head_q : slot_c;
		flt_cmd   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.mode == MODE_SENT && item.seq == nexp_q
						&& used_q < DEPTH_U) begin
					mem_we    = 1'b1;
					mem_wdata = '{retx: 1'b0, stamp: item.now_time,
						len: 32'(item.length), start: item.seq};
				end
				flt_cmd.clr = accept && (item.mode == MODE_RESET);
			end
			ST_SRCH_CMP: begin
				// mark the range retransmitted; stretch it if the resend runs past the next expected sequence
				if (match_c) begin
					mem_we    = 1'b1;
					mem_wdata = rd;
					mem_wdata.retx = 1'b1;
					if (rend_new_c > nexp_q) mem_wdata.len = rend_new_c - rd.start;
				end
			end
			ST_FILT_GO: begin
				flt_cmd.go  = 1'b1;
				flt_cmd.smp = smp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RESET[15:0];
			init_q    <= EST_RESET[31:0];
			maxm_q    <= MAXM_RESET[10:0];
			state_q   <= ST_IDLE;
			nexp_q    <= '0;
			head_q    <= '0;
			used_q    <= '0;
			i_q       <= '0;
			first_q   <= 1'b0;
			backoff_q <= 11'd1;
			smp_q     <= 1'b0;
			drop_q    <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					CFG_GAIN:     gain_q <= wr_data[15:0];
					CFG_INIT_EST: init_q <= wr_data;
					CFG_MAX_MULT: maxm_q <= wr_data[10:0];
					default: ;
				endcase
			end
			// load a new result beat, or drop the one just taken
			if (state_q == ST_OUT && (!result.valid || result.ready)) begin
				result.valid <= 1'b1;
			end else if (result.valid && result.ready) begin
				result.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						smp_q   <= 1'b0;
						drop_q  <= 1'b0;
						i_q     <= '0;
						first_q <= 1'b1;
						case (item.mode)
							MODE_SENT: begin
								if (item.seq == nexp_q) begin
									if (used_q < DEPTH_U) used_q <= used_q + UW'(1);
									else drop_q <= 1'b1;
									nexp_q <= item_end_c;
								end
							end
							MODE_BACKOFF: begin
								backoff_q <= (dbl_c < {1'b0, lim_c}) ? dbl_c[10:0] : lim_c;
							end
							MODE_CLEAR: begin
								nexp_q <= '0;
								head_q <= '0;
								used_q <= '0;
							end
							MODE_RESET: begin
								nexp_q    <= '0;
								head_q    <= '0;
								used_q    <= '0;
								backoff_q <= 11'd1;
							end
							default: ;
						endcase
					end
				end
				ST_SRCH_CMP: begin
					if (match_c) begin
						if (rend_new_c > nexp_q) nexp_q <= rend_new_c;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				ST_ACK_CMP: begin
					first_q <= 1'b0;
					// Karn: sample only a head range that was never resent
					if (take_c) begin
						smp_q     <= 1'b1;
						backoff_q <= 11'd1;
					end
					if (pop_c) begin
						head_q <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + AW'(1);
						used_q <= used_q - UW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// held beat fields and result payload, no reset
	assign pend_x = {6'b0, used_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= item.seq;
			now_q <= item.now_time;
			len_q <= 32'(item.length);
		end
		if (state_q == ST_ACK_CMP && take_c) sample_q <= now_q - rd.stamp;
		if (state_q == ST_OUT && (!result.valid || result.ready)) begin
			result.rtt_sample        <= smp_q ? sample_q : '0;
			result.sample_valid      <= smp_q;
			result.timeout_value     <= tmo;
			result.smoothed_rtt      <= est;
			result.mean_deviation    <= dev;
			result.backoff_level     <= backoff_q;
			result.history_full_drop <= drop_q;
			result.pending_ranges    <= pend_x[5:0];
		end
	end

endmodule
